@@ rtl/core/falling_sand_grid_update_assert.svh @@
// Assertion macros for the falling-sand grid update block.
`ifndef FALLING_SAND_GRID_UPDATE_ASSERT_SVH
`define FALLING_SAND_GRID_UPDATE_ASSERT_SVH

// Implication in the same cycle.
`define FSGU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define FSGU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fsgu_pkg.sv @@
// Types, codes and place pattern for the falling-sand grid update block.
package fsgu_pkg;

    typedef logic [2:0] cell_t;
    typedef logic [1:0] op_t;

    localparam op_t OP_READ  = 2'd0;
    localparam op_t OP_PLACE = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;
    localparam op_t OP_FRAME = 2'd3;

    localparam cell_t CELL_EMPTY = 3'd0;
    localparam cell_t SAND_FIRST = 3'd1;
    localparam cell_t SAND_LAST  = 3'd4;
    localparam cell_t CELL_STONE = 3'd5;

    localparam logic [2:0] PATTERN_LAST = 3'd4;

    function automatic logic is_sand(input cell_t c);
        return (c >= SAND_FIRST) && (c <= SAND_LAST);
    endfunction

    function automatic logic signed [2:0] pat_dx(input logic [2:0] k);
        logic signed [2:0] d;
        unique case (k)
            3'd1:    d = 3'sd1;
            3'd2:    d = -3'sd1;
            3'd3:    d = 3'sd2;
            3'd4:    d = -3'sd2;
            default: d = 3'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [2:0] pat_dy(input logic [2:0] k);
        logic signed [2:0] d;
        unique case (k)
            3'd1:    d = 3'sd1;
            3'd2:    d = -3'sd1;
            3'd3:    d = -3'sd1;
            3'd4:    d = 3'sd1;
            default: d = 3'sd0;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/fsgu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fsgu_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/falling_sand_grid_update.sv @@
// Falling-sand grid update: live and snapshot grids in RAM, op sequencer.
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_ready  operation, col, row, material
// out      source     out_valid / out_ready cell_code
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Frame: each scanned cell is read from the snapshot; a sand cell tests the
// cells below, below-left and below-right in turn through the single
// live-grid read port and moves to the first empty one; then a copy sweep
// and the result. After reset a clearing pass runs before the first item
// is taken.
// A result waits in the output register; the next item is taken meanwhile.
`include "falling_sand_grid_update_assert.svh"

module falling_sand_grid_update
    import fsgu_pkg::*;
#(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [6:0] col,
    input  logic [6:0] row,
    input  logic [2:0] material,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] cell_code
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);

    localparam logic [AW-1:0] H_A       = AW'(GRID_HEIGHT);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [XW-1:0] X_LAST    = XW'(GRID_WIDTH - 2);
    localparam logic [YW-1:0] Y_LAST    = YW'(GRID_HEIGHT - 2);
    localparam logic signed [11:0] W_S  = 12'(GRID_WIDTH);
    localparam logic signed [11:0] H_S  = 12'(GRID_HEIGHT);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RDREQ   = 4'd1;
    localparam logic [3:0] S_RDWAIT  = 4'd2;
    localparam logic [3:0] S_PLACE   = 4'd3;
    localparam logic [3:0] S_CLEAR   = 4'd4;
    localparam logic [3:0] S_FSNAP   = 4'd5;
    localparam logic [3:0] S_FEVAL   = 4'd6;
    localparam logic [3:0] S_FBL     = 4'd7;
    localparam logic [3:0] S_FBR     = 4'd8;
    localparam logic [3:0] S_FWSRC   = 4'd9;
    localparam logic [3:0] S_FWDST   = 4'd10;
    localparam logic [3:0] S_COPY    = 4'd11;
    localparam logic [3:0] S_COPYEND = 4'd12;
    localparam logic [3:0] S_RESP    = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic          resp_reg, resp_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [2:0]    k_reg, k_next;
    logic          cp_v_reg, cp_v_next;
    logic [AW-1:0] cp_addr_reg, cp_addr_next;
    logic          out_valid_reg, out_valid_next;
    cell_t         cell_code_reg, cell_code_next;

    logic [6:0]    col_reg, col_next;
    logic [6:0]    row_reg, row_next;
    cell_t         mat_reg, mat_next;
    cell_t         res_reg, res_next;
    logic [XW-1:0] fx_reg, fx_next;
    logic [YW-1:0] fy_reg, fy_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] tgt_reg, tgt_next;
    cell_t         c_reg, c_next;

    logic signed [2:0]  dx, dy;
    logic signed [11:0] px, py;
    logic               pos_on;
    logic [AW-1:0]      pos_addr;
    logic               mat_ok;
    logic [AW-1:0]      below_addr, bl_addr, br_addr;
    logic               last_cell;

    logic          live_we;
    logic [AW-1:0] live_waddr, live_raddr;
    cell_t         live_wdata, live_rdata;
    logic          snap_we;
    logic [AW-1:0] snap_waddr;
    cell_t         snap_wdata, snap_rdata;
    logic          snap_phase;

    fsgu_ram #(.WIDTH(3), .DEPTH(CELLS)) u_live (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (live_raddr),
        .rdata (live_rdata)
    );

    fsgu_ram #(.WIDTH(3), .DEPTH(CELLS)) u_snap (
        .clk   (clk),
        .we    (snap_we),
        .waddr (snap_waddr),
        .wdata (snap_wdata),
        .raddr (addr_reg),
        .rdata (snap_rdata)
    );

    // addressed cell for read and place, pattern offset k
    assign dx       = pat_dx(k_reg);
    assign dy       = pat_dy(k_reg);
    assign px       = $signed({5'b0, col_reg}) + {{9{dx[2]}}, dx};
    assign py       = $signed({5'b0, row_reg}) + {{9{dy[2]}}, dy};
    assign pos_on   = !px[11] && !py[11] && (px < W_S) && (py < H_S);
    assign pos_addr = AW'(px[10:0]) * H_A + AW'(py[10:0]);
    assign mat_ok   = is_sand(mat_reg) || ((k_reg == 3'd0) && (mat_reg == CELL_STONE));

    assign below_addr = addr_reg + AW'(1);
    assign bl_addr    = below_addr - H_A;
    assign br_addr    = below_addr + H_A;
    assign last_cell  = (fx_reg == X_LAST) && (fy_reg == Y_LAST);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign cell_code = cell_code_reg;

    // memory ports
    always_comb
    begin
        live_we    = 1'b0;
        live_waddr = pos_addr;
        live_wdata = mat_reg;
        live_raddr = pos_addr;
        unique case (state_reg)
            S_PLACE:
            begin
                live_we = mat_ok && pos_on;
            end
            S_CLEAR:
            begin
                live_we    = 1'b1;
                live_waddr = cnt_reg;
                live_wdata = CELL_EMPTY;
            end
            S_FSNAP:
            begin
                live_raddr = below_addr;
            end
            S_FEVAL:
            begin
                live_raddr = (fx_reg != '0) ? bl_addr : br_addr;
            end
            S_FBL:
            begin
                live_raddr = br_addr;
            end
            S_FWSRC:
            begin
                live_we    = 1'b1;
                live_waddr = addr_reg;
                live_wdata = CELL_EMPTY;
            end
            S_FWDST:
            begin
                live_we    = 1'b1;
                live_waddr = tgt_reg;
                live_wdata = c_reg;
            end
            S_COPY:
            begin
                live_raddr = cnt_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign snap_we    = (state_reg == S_CLEAR) || cp_v_reg;
    assign snap_waddr = (state_reg == S_CLEAR) ? cnt_reg : cp_addr_reg;
    assign snap_wdata = (state_reg == S_CLEAR) ? CELL_EMPTY : live_rdata;
    assign snap_phase = (state_reg == S_CLEAR) || (state_reg == S_COPY)
                        || (state_reg == S_COPYEND);

    // sequencer
    always_comb
    begin
        logic adv;
        adv            = 1'b0;
        state_next     = state_reg;
        resp_next      = resp_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        cp_v_next      = 1'b0;
        cp_addr_next   = cp_addr_reg;
        out_valid_next = out_valid_reg;
        cell_code_next = cell_code_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        mat_next       = mat_reg;
        res_next       = res_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        addr_next      = addr_reg;
        tgt_next       = tgt_reg;
        c_next         = c_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    col_next  = col;
                    row_next  = row;
                    mat_next  = material;
                    res_next  = CELL_EMPTY;
                    k_next    = 3'd0;
                    cnt_next  = '0;
                    resp_next = 1'b1;
                    fx_next   = '0;
                    fy_next   = '0;
                    addr_next = '0;
                    unique case (operation)
                        OP_READ:  state_next = S_RDREQ;
                        OP_PLACE: state_next = S_PLACE;
                        OP_CLEAR: state_next = S_CLEAR;
                        OP_FRAME: state_next = S_FSNAP;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_RDREQ:
            begin
                state_next = S_RDWAIT;
            end
            S_RDWAIT:
            begin
                res_next   = pos_on ? live_rdata : CELL_EMPTY;
                state_next = S_RESP;
            end
            S_PLACE:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == PATTERN_LAST)
                begin
                    state_next = S_RESP;
                end
            end
            S_CLEAR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_FSNAP:
            begin
                state_next = S_FEVAL;
            end
            S_FEVAL:
            begin
                c_next = snap_rdata;
                if (!is_sand(snap_rdata))
                begin
                    adv = 1'b1;
                end
                else if (live_rdata == CELL_EMPTY)
                begin
                    tgt_next   = below_addr;
                    state_next = S_FWSRC;
                end
                else
                begin
                    state_next = (fx_reg != '0) ? S_FBL : S_FBR;
                end
            end
            S_FBL:
            begin
                if (live_rdata == CELL_EMPTY)
                begin
                    tgt_next   = bl_addr;
                    state_next = S_FWSRC;
                end
                else
                begin
                    state_next = S_FBR;
                end
            end
            S_FBR:
            begin
                if (live_rdata == CELL_EMPTY)
                begin
                    tgt_next   = br_addr;
                    state_next = S_FWSRC;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            S_FWSRC:
            begin
                state_next = S_FWDST;
            end
            S_FWDST:
            begin
                adv = 1'b1;
            end
            S_COPY:
            begin
                cp_v_next    = 1'b1;
                cp_addr_next = cnt_reg;
                cnt_next     = cnt_reg + AW'(1);
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_COPYEND;
                end
            end
            S_COPYEND:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    cell_code_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next scan cell, columns outer, last row and column skipped
        if (adv)
        begin
            if (last_cell)
            begin
                cnt_next   = '0;
                state_next = S_COPY;
            end
            else
            begin
                state_next = S_FSNAP;
                if (fy_reg == Y_LAST)
                begin
                    fy_next   = '0;
                    fx_next   = fx_reg + XW'(1);
                    addr_next = addr_reg + AW'(2);
                end
                else
                begin
                    fy_next   = fy_reg + YW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            resp_reg      <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            cp_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resp_reg      <= resp_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            cp_v_reg      <= cp_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg   <= cp_addr_next;
        cell_code_reg <= cell_code_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        mat_reg       <= mat_next;
        res_reg       <= res_next;
        fx_reg        <= fx_next;
        fy_reg        <= fy_next;
        addr_reg      <= addr_next;
        tgt_reg       <= tgt_next;
        c_reg         <= c_next;
    end

    `FSGU_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item taken while busy")
    `FSGU_ASSERT_NOW(a_snap_write, snap_we, snap_phase, "snapshot written outside clear or copy")
    `FSGU_ASSERT_NOW(a_out_source, $rose(out_valid_reg), $past(state_reg == S_RESP), "bad result")
    `FSGU_ASSERT_NOW(a_move_sand, state_reg == S_FWDST, is_sand(c_reg), "moved cell is not sand")

endmodule

@@ test/testbench.sv @@
// Testbench for falling_sand_grid_update: directed and random operations against a predictor.
module testbench
    import fsgu_pkg::*;
();

    localparam int GRID_W = 128;
    localparam int GRID_H = 128;
    localparam int QUIET_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 70;
    localparam int MAX_SPOTS = 32;
    localparam cell_t SAND_SECOND = SAND_FIRST + 3'd1;
    localparam cell_t SAND_THIRD = SAND_FIRST + 3'd2;
    localparam logic [2:0] MAT_SPARE_LO = 3'd6;
    localparam logic [2:0] MAT_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    op_t operation = OP_READ;
    logic [6:0] col = '0;
    logic [6:0] row = '0;
    logic [2:0] material = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] cell_code;

    cell_t live_cells [GRID_W][GRID_H];
    cell_t snap_cells [GRID_W][GRID_H];
    cell_t pending_codes [$];
    logic [13:0] placed_spots [$];
    bit steady = 1'b0;
    bit mismatch_seen = 1'b0;

    falling_sand_grid_update dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void wipe_grids();
        foreach (live_cells[x, y])
        begin
            live_cells[x][y] = CELL_EMPTY;
            snap_cells[x][y] = CELL_EMPTY;
        end
    endfunction

    function automatic bit sand_code(input cell_t c);
        return (c >= SAND_FIRST) && (c <= SAND_LAST);
    endfunction

    function automatic void put_cell(input int x, input int y, input cell_t c);
        if (x >= 0 && x < GRID_W && y >= 0 && y < GRID_H)
            live_cells[x][y] = c;
    endfunction

    function automatic void place_material(input int x, input int y, input cell_t m);
        if (sand_code(m))
        begin
            put_cell(x, y, m);
            put_cell(x + 1, y + 1, m);
            put_cell(x - 1, y - 1, m);
            put_cell(x + 2, y - 1, m);
            put_cell(x - 2, y + 1, m);
        end
        else if (m == CELL_STONE)
            put_cell(x, y, m);
    endfunction

    function automatic void advance_frame();
        cell_t c;
        for (int x = 0; x < GRID_W - 1; x++)
            for (int y = 0; y < GRID_H - 1; y++)
            begin
                c = snap_cells[x][y];
                if (sand_code(c))
                begin
                    if (live_cells[x][y + 1] == CELL_EMPTY)
                    begin
                        live_cells[x][y] = CELL_EMPTY;
                        live_cells[x][y + 1] = c;
                    end
                    else if (x > 0 && live_cells[x - 1][y + 1] == CELL_EMPTY)
                    begin
                        live_cells[x][y] = CELL_EMPTY;
                        live_cells[x - 1][y + 1] = c;
                    end
                    else if (live_cells[x + 1][y + 1] == CELL_EMPTY)
                    begin
                        live_cells[x][y] = CELL_EMPTY;
                        live_cells[x + 1][y + 1] = c;
                    end
                end
            end
        foreach (live_cells[x, y])
            snap_cells[x][y] = live_cells[x][y];
    endfunction

    function automatic cell_t predict_cell_code(input op_t op, input logic [6:0] c,
                                                input logic [6:0] r, input logic [2:0] m);
        cell_t code;
        code = CELL_EMPTY;
        case (op)
            OP_READ:  code = live_cells[c][r];
            OP_PLACE: place_material(c, r, m);
            OP_CLEAR: wipe_grids();
            default:  advance_frame();
        endcase
        return code;
    endfunction

    always @(posedge clk)
    begin : result_check
        cell_t want;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                if (pending_codes.size() == 0)
                begin
                    $display("%0t: cell_code expected none, got %0d", $time, cell_code);
                    mismatch_seen = 1'b1;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (cell_code !== want)
                    begin
                        $display("%0t: cell_code expected %0d, got %0d", $time, want, cell_code);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if (in_valid && in_ready === 1'b1)
                pending_codes.push_back(predict_cell_code(operation, col, row, material));
        end
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 30);

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[falling_sand_grid_update] ERROR");
        $finish;
    end

    task automatic send_item(input op_t op, input logic [6:0] c, input logic [6:0] r,
                             input logic [2:0] m);
        while (!steady && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        col <= c;
        row <= r;
        material <= m;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic test_empty_grid();
        send_item(OP_READ, 0, 0, CELL_EMPTY);
        send_item(OP_READ, 127, 127, CELL_EMPTY);
    endtask

    // pattern cells past the grid edges are dropped; spare codes change nothing
    task automatic test_place_edges();
        send_item(OP_PLACE, 0, 0, SAND_FIRST);
        send_item(OP_PLACE, 127, 127, SAND_LAST);
        send_item(OP_PLACE, 127, 0, CELL_STONE);
        send_item(OP_PLACE, 5, 5, CELL_EMPTY);
        send_item(OP_PLACE, 5, 5, MAT_SPARE_LO);
        send_item(OP_PLACE, 5, 5, MAT_SPARE_HI);
        send_item(OP_READ, 1, 1, CELL_EMPTY);
        send_item(OP_READ, 126, 126, CELL_EMPTY);
        send_item(OP_READ, 127, 0, CELL_EMPTY);
        send_item(OP_READ, 5, 5, CELL_EMPTY);
    endtask

    // falls, slides, left edge, blocked on all sides; first frame after clear only copies
    task automatic test_frame_moves();
        send_item(OP_CLEAR, 0, 0, CELL_EMPTY);
        send_item(OP_READ, 127, 127, CELL_EMPTY);
        send_item(OP_PLACE, 10, 0, SAND_SECOND);
        send_item(OP_PLACE, 10, 2, CELL_STONE);
        send_item(OP_PLACE, 9, 2, CELL_STONE);
        send_item(OP_PLACE, 0, 40, SAND_THIRD);
        send_item(OP_PLACE, 0, 41, CELL_STONE);
        send_item(OP_PLACE, 64, 64, SAND_LAST);
        send_item(OP_PLACE, 64, 65, CELL_STONE);
        send_item(OP_PLACE, 63, 65, CELL_STONE);
        send_item(OP_FRAME, 0, 0, CELL_EMPTY);
        send_item(OP_FRAME, 0, 0, CELL_EMPTY);
        send_item(OP_FRAME, 0, 0, CELL_EMPTY);
        send_item(OP_READ, 10, 1, CELL_EMPTY);
        send_item(OP_READ, 0, 40, CELL_EMPTY);
        send_item(OP_READ, 64, 64, CELL_EMPTY);
        send_item(OP_READ, 65, 66, CELL_EMPTY);
    endtask

    // mostly places and reads clustered around earlier places, a few frames and clears
    task automatic test_random_traffic(input int count);
        op_t op;
        logic [6:0] c, r, spot_c, spot_r;
        logic [2:0] m;
        int roll, sent, frames_left, clears_left;
        sent = 0;
        frames_left = 6;
        clears_left = 2;
        while (sent < count)
        begin
            steady = (sent >= count / 3) && (sent < 2 * count / 3);
            if (placed_spots.size() > 0 && $urandom_range(0, 1))
            begin
                {spot_c, spot_r} = placed_spots[$urandom_range(0, placed_spots.size() - 1)];
                c = 7'(spot_c + $urandom_range(0, 4) - 2);
                r = 7'(spot_r + $urandom_range(0, 4) - 2);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                c = 7'($urandom_range(0, 1) ? $urandom_range(0, 1) : 126 + $urandom_range(0, 1));
                r = 7'($urandom_range(0, 1) ? $urandom_range(0, 1) : 126 + $urandom_range(0, 1));
            end
            else
            begin
                c = 7'($urandom_range(0, 127));
                r = 7'($urandom_range(0, 127));
            end
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       m = CELL_EMPTY;
                    1:       m = MAT_SPARE_LO;
                    default: m = MAT_SPARE_HI;
                endcase
            end
            else
                m = 3'($urandom_range(SAND_FIRST, CELL_STONE));
            roll = $urandom_range(0, 99);
            if (roll < 5 && frames_left > 0)
            begin
                op = OP_FRAME;
                frames_left--;
            end
            else if (roll < 7 && clears_left > 0)
            begin
                op = OP_CLEAR;
                clears_left--;
            end
            else if (roll < 50)
                op = OP_PLACE;
            else
                op = OP_READ;
            send_item(op, c, r, m);
            if (op == OP_PLACE && m >= SAND_FIRST && m <= CELL_STONE)
            begin
                placed_spots.push_back({c, r});
                if (placed_spots.size() > MAX_SPOTS)
                    void'(placed_spots.pop_front());
            end
            if (!(op == OP_PLACE && (m == CELL_EMPTY || m > CELL_STONE)))
                sent++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        wipe_grids();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_grid();
        test_place_edges();
        test_frame_moves();
        test_random_traffic(RANDOM_ITEMS);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!mismatch_seen)
            $display("[falling_sand_grid_update] OK");
        else
            $display("[falling_sand_grid_update] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/fsgu_pkg.sv
rtl/core/fsgu_ram.sv
rtl/core/falling_sand_grid_update.sv
test/testbench.sv
